@@ rtl/binary_stl_record_deframer_macros.svh @@
// Assertion macros used by the deframer's top-level RTL file.
`ifndef BINARY_STL_RECORD_DEFRAMER_MACROS_SVH
`define BINARY_STL_RECORD_DEFRAMER_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define BSRD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsrd: implication check failed");

// The expression must never be true.
`define BSRD_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("bsrd: forbidden condition seen");

`endif

@@ rtl/bsrd_pkg.sv @@
// Types, constants and small tables shared by the deframer modules.
package bsrd_pkg;

  localparam int unsigned HEADER_BYTES = 80;
  localparam int unsigned RECORD_BYTES = 50;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEFAULT_RED   = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_GREEN = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_BLUE  = 2'd2;

  // Vector kinds.
  localparam logic [1:0] KIND_NORMAL   = 2'd0;
  localparam logic [1:0] KIND_VERTEX_A = 2'd1;
  localparam logic [1:0] KIND_VERTEX_B = 2'd2;
  localparam logic [1:0] KIND_VERTEX_C = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_VECTOR = 2'd0;
  localparam logic [1:0] STAT_TEXT   = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;

  localparam logic [7:0] DEFAULT_RED_RST   = 8'd90;
  localparam logic [7:0] DEFAULT_GREEN_RST = 8'd120;
  localparam logic [7:0] DEFAULT_BLUE_RST  = 8'd140;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  vector_kind;
    logic [31:0] x_bits;
    logic [31:0] y_bits;
    logic [31:0] z_bits;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_of_file;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [1:0] slot;   // which of the three words of a vector
    logic [1:0] group;  // which vector of the record
  } word_place_t;

  // Characters of the text-STL marker "solid".
  function automatic logic [7:0] text_mark(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h73;
      3'd1:    ch = 8'h6f;
      3'd2:    ch = 8'h6c;
      3'd3:    ch = 8'h69;
      3'd4:    ch = 8'h64;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Splits a word number within a record into vector and component.
  function automatic word_place_t word_place(input logic [3:0] w);
    word_place_t wp;
    case (w)
      4'd0:    wp = '{slot: 2'd0, group: 2'd0};
      4'd1:    wp = '{slot: 2'd1, group: 2'd0};
      4'd2:    wp = '{slot: 2'd2, group: 2'd0};
      4'd3:    wp = '{slot: 2'd0, group: 2'd1};
      4'd4:    wp = '{slot: 2'd1, group: 2'd1};
      4'd5:    wp = '{slot: 2'd2, group: 2'd1};
      4'd6:    wp = '{slot: 2'd0, group: 2'd2};
      4'd7:    wp = '{slot: 2'd1, group: 2'd2};
      4'd8:    wp = '{slot: 2'd2, group: 2'd2};
      4'd9:    wp = '{slot: 2'd0, group: 2'd3};
      4'd10:   wp = '{slot: 2'd1, group: 2'd3};
      4'd11:   wp = '{slot: 2'd2, group: 2'd3};
      default: wp = '{slot: 2'd0, group: 2'd3};
    endcase
    return wp;
  endfunction

endpackage

@@ rtl/binary_stl_record_deframer.sv @@
// Top level of the binary STL deframer: parser front end and result queue.
//
//   Channel   Direction  Handshake              Payload
//   input     in         push / full            in_i     (data_byte, file_start)
//   result    out        pop / empty            result_o (vector, colour, status)
//   config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// Each byte is parsed in the cycle it is accepted; while not full, one byte per cycle is taken.
// A result item is held in the queue and shown once the items ahead of it are popped.
// The four-entry queue fills only while pop is held low; full then stalls input.
// Reset clears the parser to the header phase and the defaults to 90/120/140.
module binary_stl_record_deframer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  bsrd_pkg::in_item_t  in_i,
  output logic                empty,
  input  logic                pop,
  output bsrd_pkg::out_item_t result_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);
  import bsrd_pkg::*;

  `include "binary_stl_record_deframer_macros.svh"

  logic      accept;
  logic      q_wr;
  out_item_t q_item;

  assign accept = push && !full;

  bsrd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_i         (in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_o (q_wr),
    .item_o       (q_item)
  );

  bsrd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_item_i (q_item),
    .rd_i      (pop),
    .rd_item_o (result_o),
    .full_o    (full),
    .empty_o   (empty)
  );

  // The parser only produces an item for a byte that was actually taken.
  `BSRD_ASSERT_IMPL(a_item_needs_byte, q_wr, accept)
  // Status items always close the file.
  `BSRD_ASSERT_IMPL(a_status_is_last, !empty && result_o.status != STAT_VECTOR,
                    result_o.last_of_file && result_o.vector_kind == KIND_NORMAL)
  // Among vector items, only vertex c carries a colour or the end of file.
  `BSRD_ASSERT_IMPL(a_colour_on_vertex_c,
                    !empty && result_o.status == STAT_VECTOR &&
                    result_o.vector_kind != KIND_VERTEX_C,
                    !result_o.last_of_file && result_o.red == 8'd0 &&
                    result_o.green == 8'd0 && result_o.blue == 8'd0)

endmodule

@@ rtl/bsrd_front.sv @@
// Byte parser: walks header, count and records and produces result items.
module bsrd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  bsrd_pkg::in_item_t in_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  output logic              item_valid_o,
  output bsrd_pkg::out_item_t item_o
);
  import bsrd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_COUNT,
    PH_RECORDS,
    PH_DONE
  } phase_e;

  localparam int unsigned HDR_W = $clog2(HEADER_BYTES);
  localparam int unsigned REC_W = $clog2(RECORD_BYTES);
  localparam logic [HDR_W-1:0] HDR_LAST   = HDR_W'(HEADER_BYTES - 1);
  localparam logic [REC_W-1:0] REC_ATTR_LO = REC_W'(RECORD_BYTES - 2);
  localparam logic [REC_W-1:0] REC_ATTR_HI = REC_W'(RECORD_BYTES - 1);

  phase_e            phase_q, phase_d, phase_c;
  logic [HDR_W-1:0]  hdr_pos_q, hdr_pos_d, hdr_pos_c;
  logic              match_q, match_d, match_c;
  logic [REC_W-1:0]  rec_pos_q, rec_pos_d, rec_pos_c;
  logic [31:0]       tri_left_q, tri_left_d, tri_dec;
  logic [31:0]       word_q, word_d, word_shift;
  logic [31:0]       vec_q [3];
  logic [7:0]        color_lo_q, color_lo_d;
  logic [7:0]        def_red_q, def_green_q, def_blue_q;
  logic              vec_we;
  word_place_t       place;
  logic [15:0]       attr;
  logic              item_valid;
  out_item_t         item;

  assign word_shift = {in_i.data_byte, word_q[31:8]};
  assign place      = word_place(rec_pos_c[5:2]);
  assign attr       = {in_i.data_byte, color_lo_q};
  assign tri_dec    = tri_left_q - 32'd1;

  always_comb begin
    phase_c   = in_i.file_start ? PH_HEADER : phase_q;
    hdr_pos_c = in_i.file_start ? '0 : hdr_pos_q;
    match_c   = in_i.file_start ? 1'b1 : match_q;
    rec_pos_c = in_i.file_start ? '0 : rec_pos_q;

    phase_d    = phase_q;
    hdr_pos_d  = hdr_pos_q;
    match_d    = match_q;
    rec_pos_d  = rec_pos_q;
    tri_left_d = tri_left_q;
    word_d     = word_q;
    color_lo_d = color_lo_q;
    vec_we     = 1'b0;
    item_valid = 1'b0;
    item       = '0;

    if (accept_i) begin
      phase_d   = phase_c;
      hdr_pos_d = hdr_pos_c;
      match_d   = match_c;
      rec_pos_d = rec_pos_c;
      unique case (phase_c)
        PH_HEADER: begin
          if (hdr_pos_c < HDR_W'(5) && in_i.data_byte != text_mark(hdr_pos_c[2:0])) begin
            match_d = 1'b0;
          end
          if (hdr_pos_c == HDR_LAST) begin
            hdr_pos_d = '0;
            if (match_d) begin
              phase_d           = PH_DONE;
              item_valid        = 1'b1;
              item.last_of_file = 1'b1;
              item.status       = STAT_TEXT;
            end else begin
              phase_d   = PH_COUNT;
              rec_pos_d = '0;
              word_d    = '0;
            end
          end else begin
            hdr_pos_d = hdr_pos_c + HDR_W'(1);
          end
        end
        PH_COUNT: begin
          word_d    = word_shift;
          rec_pos_d = rec_pos_c + REC_W'(1);
          if (rec_pos_c == REC_W'(3)) begin
            rec_pos_d  = '0;
            tri_left_d = word_shift;
            if (word_shift == 32'd0) begin
              phase_d           = PH_DONE;
              item_valid        = 1'b1;
              item.last_of_file = 1'b1;
              item.status       = STAT_EMPTY;
            end else begin
              phase_d = PH_RECORDS;
            end
          end
        end
        PH_RECORDS: begin
          if (rec_pos_c < REC_ATTR_LO) begin
            word_d    = word_shift;
            rec_pos_d = rec_pos_c + REC_W'(1);
            if (rec_pos_c[1:0] == 2'd3) begin
              vec_we = 1'b1;
              // The third word of each vector but vertex c goes out directly, bypassing its register.
              if (place.slot == 2'd2 && place.group != KIND_VERTEX_C) begin
                item_valid       = 1'b1;
                item.vector_kind = place.group;
                item.x_bits      = vec_q[0];
                item.y_bits      = vec_q[1];
                item.z_bits      = word_shift;
                item.status      = STAT_VECTOR;
              end
            end
          end else if (rec_pos_c == REC_ATTR_LO) begin
            color_lo_d = in_i.data_byte;
            rec_pos_d  = REC_ATTR_HI;
          end else begin
            tri_left_d       = tri_dec;
            rec_pos_d        = '0;
            item_valid       = 1'b1;
            item.vector_kind = KIND_VERTEX_C;
            item.x_bits      = vec_q[0];
            item.y_bits      = vec_q[1];
            item.z_bits      = vec_q[2];
            item.status      = STAT_VECTOR;
            if (attr[15]) begin
              item.red   = {attr[14:10], 3'b000};
              item.green = {attr[9:5], 3'b000};
              item.blue  = {attr[4:0], 3'b000};
            end else begin
              item.red   = def_red_q;
              item.green = def_green_q;
              item.blue  = def_blue_q;
            end
            if (tri_dec == 32'd0) begin
              item.last_of_file = 1'b1;
              phase_d           = PH_DONE;
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_pos_q   <= '0;
      match_q     <= 1'b1;
      rec_pos_q   <= '0;
      tri_left_q  <= '0;
      word_q      <= '0;
      color_lo_q  <= '0;
      def_red_q   <= DEFAULT_RED_RST;
      def_green_q <= DEFAULT_GREEN_RST;
      def_blue_q  <= DEFAULT_BLUE_RST;
    end else begin
      phase_q    <= phase_d;
      hdr_pos_q  <= hdr_pos_d;
      match_q    <= match_d;
      rec_pos_q  <= rec_pos_d;
      tri_left_q <= tri_left_d;
      word_q     <= word_d;
      color_lo_q <= color_lo_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DEFAULT_RED:   def_red_q   <= cfg_data_i;
          CFG_DEFAULT_GREEN: def_green_q <= cfg_data_i;
          CFG_DEFAULT_BLUE:  def_blue_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Vector words are always written within a record before they are read.
  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_q[place.slot] <= word_shift;
    end
  end

  assign item_valid_o = item_valid;
  assign item_o       = item;

endmodule

@@ rtl/bsrd_queue.sv @@
// Short result queue between the parser and the result port.
module bsrd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  bsrd_pkg::out_item_t wr_item_i,
  input  logic                rd_i,
  output bsrd_pkg::out_item_t rd_item_o,
  output logic                full_o,
  output logic                empty_o
);
  import bsrd_pkg::*;

  out_item_t              entries_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q;
  logic                   do_wr, do_rd;

  assign full_o  = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + (QUEUE_PTR_W+1)'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - (QUEUE_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= wr_item_i;
    end
  end

  assign rd_item_o = entries_q[rd_ptr_q];

endmodule
